@@ rtl/kcfc_pkg.sv @@
// kicker charge and fire control: shared types, codes and band tables
package kcfc_pkg;

	// request fields as they arrive from the tick source
	typedef struct packed {
		logic [11:0] adc_code;
		logic [31:0] now_us;
		logic [3:0]  kick_power;
		logic [2:0]  kick_mode;
		logic        deep_sensor_level;
		logic        front_sensor_level;
	} req_t;

	// result fields, taken from the state after the tick, plus the measured voltage of the tick
	typedef struct packed {
		logic        charge_level;
		logic        discharge_level;
		logic        straight_level;
		logic        chip_level;
		logic        led_deep;
		logic        led_front;
		logic        ready_res;
		logic [1:0]  phase_out;
		logic [15:0] cap_centivolts;
	} rsp_t;

	// request after scaling: converter code replaced by converter millivolts (0.14 V each)
	typedef struct packed {
		logic [11:0] volt_code;
		logic [31:0] now_us;
		logic [3:0]  kick_power;
		logic [2:0]  kick_mode;
		logic        deep_n;
		logic        front_n;
	} stage_t;

	// sequencer phases
	localparam logic [1:0] PH_PREPARE = 2'd0;
	localparam logic [1:0] PH_KICK    = 2'd1;
	localparam logic [1:0] PH_AFTER   = 2'd2;

	// kick modes
	localparam logic [2:0] MODE_OFF           = 3'd0;
	localparam logic [2:0] MODE_KICK_FRONT    = 3'd1;
	localparam logic [2:0] MODE_KICK_UP       = 3'd2;
	localparam logic [2:0] MODE_AUTO_FRONT    = 3'd3;
	localparam logic [2:0] MODE_AUTO_UP       = 3'd4;
	localparam logic [2:0] MODE_AUTO_MOMENTUM = 3'd5;

	// pin bit positions in the level vector
	localparam int PIN_CHARGE    = 0;
	localparam int PIN_DISCHARGE = 1;
	localparam int PIN_STRAIGHT  = 2;
	localparam int PIN_CHIP      = 3;

	// re-arm delay after a kick, microseconds
	localparam logic [31:0] SETTLE_US = 32'd10000;

	// 10 V in units of 1/1400 V
	localparam logic [19:0] VOLT_10 = 20'd14000;

	// code*3300/4095 == code*220/273, done as code * ceil(2^30/273)*220 >> 30 (exact for 12 bits)
	localparam logic [29:0] DIV_RECIP = 30'd865286620;

	// lower edge of the band (target - bound), in 1/1400 V
	function automatic logic signed [20:0] band_lo(input logic [3:0] power);
		logic signed [20:0] lo;
		unique case (power)
			4'd0:    lo = -21'sd7000;
			4'd1:    lo = 21'sd133000;
			4'd2:    lo = 21'sd154850;
			4'd3:    lo = 21'sd176700;
			4'd4:    lo = 21'sd198550;
			4'd5:    lo = 21'sd220400;
			4'd6:    lo = 21'sd242250;
			4'd7:    lo = 21'sd264100;
			4'd8:    lo = 21'sd287000;
			4'd9:    lo = 21'sd310000;
			4'd10:   lo = 21'sd333000;
			4'd11:   lo = 21'sd356000;
			4'd12:   lo = 21'sd379000;
			4'd13:   lo = 21'sd402000;
			4'd14:   lo = 21'sd425000;
			default: lo = 21'sd448000;
		endcase
		return lo;
	endfunction

	// upper edge of the band (target + bound), in 1/1400 V
	function automatic logic signed [20:0] band_hi(input logic [3:0] power);
		logic signed [20:0] hi;
		unique case (power)
			4'd0:    hi = 21'sd7000;
			4'd1:    hi = 21'sd147000;
			4'd2:    hi = 21'sd171150;
			4'd3:    hi = 21'sd195300;
			4'd4:    hi = 21'sd219450;
			4'd5:    hi = 21'sd243600;
			4'd6:    hi = 21'sd267750;
			4'd7:    hi = 21'sd291900;
			4'd8:    hi = 21'sd315000;
			4'd9:    hi = 21'sd338000;
			4'd10:   hi = 21'sd361000;
			4'd11:   hi = 21'sd384000;
			4'd12:   hi = 21'sd407000;
			4'd13:   hi = 21'sd430000;
			4'd14:   hi = 21'sd453000;
			default: hi = 21'sd476000;
		endcase
		return hi;
	endfunction

endpackage

@@ rtl/kcfc_scale.sv @@
// converter code to capacitor volts scaling, code*3300/4095 by reciprocal multiply
module kcfc_scale (
	input  logic [11:0] adc_code,
	output logic [11:0] volt_code
);

	logic [41:0] prod;

	// one 12x30 constant multiply, top bits are the exact quotient
	assign prod      = 42'(adc_code) * 42'(kcfc_pkg::DIV_RECIP);
	assign volt_code = prod[41:30];

endmodule

@@ rtl/kcfc_ctrl.sv @@
// band control and prepare/kick/after-kick sequencer with result registers
module kcfc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  kcfc_pkg::stage_t item,
	output kcfc_pkg::rsp_t   rsp
);

	logic [1:0]  phase_q, phase_d;
	logic        in_band_q, in_band_d;
	logic [31:0] fire_time_q, fire_time_d;
	logic [3:0]  pins_q, pins_d;
	logic [1:0]  leds_q, leds_d;
	logic [15:0] cap_q;

	logic [19:0]        actual;
	logic signed [20:0] actual_s;
	logic signed [20:0] lo;
	logic signed [20:0] hi;
	logic [31:0]        elapsed;
	logic               fire_now;
	logic               fire_chip;

	// capacitor voltage in 1/1400 V and the band edges for this power
	assign actual   = 20'(item.volt_code) * 20'd196;
	assign actual_s = signed'({1'b0, actual});
	assign lo       = kcfc_pkg::band_lo(item.kick_power);
	assign hi       = kcfc_pkg::band_hi(item.kick_power);
	assign elapsed  = item.now_us - fire_time_q;

	// which solenoid, if any, this mode fires in the kick phase
	always_comb begin
		fire_now  = 1'b0;
		fire_chip = 1'b0;
		unique case (item.kick_mode)
			kcfc_pkg::MODE_KICK_FRONT: fire_now = 1'b1;
			kcfc_pkg::MODE_KICK_UP: begin
				fire_now  = 1'b1;
				fire_chip = 1'b1;
			end
			kcfc_pkg::MODE_AUTO_FRONT: fire_now = item.deep_n && item.front_n;
			kcfc_pkg::MODE_AUTO_UP: begin
				fire_now  = item.deep_n && item.front_n;
				fire_chip = 1'b1;
			end
			kcfc_pkg::MODE_AUTO_MOMENTUM: fire_now = item.deep_n || item.front_n;
			default: fire_now = 1'b0;
		endcase
	end

	// next state for one tick
	always_comb begin
		phase_d     = phase_q;
		in_band_d   = in_band_q;
		fire_time_d = fire_time_q;
		pins_d      = pins_q;
		leds_d      = leds_q;
		priority if (phase_q == kcfc_pkg::PH_PREPARE || !in_band_q) begin
			pins_d[kcfc_pkg::PIN_STRAIGHT] = 1'b1;
			pins_d[kcfc_pkg::PIN_CHIP]     = 1'b1;
			priority if (actual_s < lo) begin
				pins_d[kcfc_pkg::PIN_DISCHARGE] = 1'b1;
				pins_d[kcfc_pkg::PIN_CHARGE]    = 1'b0;
				in_band_d = 1'b0;
			end else if (actual_s > hi) begin
				pins_d[kcfc_pkg::PIN_DISCHARGE] = 1'b0;
				pins_d[kcfc_pkg::PIN_CHARGE]    = 1'b1;
				in_band_d = 1'b0;
			end else begin
				pins_d[kcfc_pkg::PIN_DISCHARGE] = 1'b1;
				pins_d[kcfc_pkg::PIN_CHARGE]    = 1'b1;
				in_band_d = 1'b1;
				if (item.kick_mode != kcfc_pkg::MODE_OFF) begin
					phase_d = kcfc_pkg::PH_KICK;
				end
			end
			leds_d = {item.front_n, item.deep_n};
		end else if (phase_q == kcfc_pkg::PH_KICK) begin
			pins_d[kcfc_pkg::PIN_DISCHARGE] = 1'b1;
			pins_d[kcfc_pkg::PIN_CHARGE]    = 1'b1;
			phase_d = kcfc_pkg::PH_PREPARE;
			if (fire_now) begin
				fire_time_d = item.now_us;
				phase_d     = kcfc_pkg::PH_AFTER;
				if (fire_chip) begin
					pins_d[kcfc_pkg::PIN_CHIP] = 1'b0;
				end else begin
					pins_d[kcfc_pkg::PIN_STRAIGHT] = 1'b0;
				end
			end
		end else if (phase_q == kcfc_pkg::PH_AFTER) begin
			if (elapsed > kcfc_pkg::SETTLE_US && actual < kcfc_pkg::VOLT_10) begin
				phase_d = kcfc_pkg::PH_PREPARE;
			end
		end else begin
			phase_d = phase_q;
		end
	end

	// state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= kcfc_pkg::PH_PREPARE;
			in_band_q   <= 1'b0;
			fire_time_q <= '0;
			pins_q      <= 4'b1111;
			leds_q      <= 2'b00;
		end else if (upd) begin
			phase_q     <= phase_d;
			in_band_q   <= in_band_d;
			fire_time_q <= fire_time_d;
			pins_q      <= pins_d;
			leds_q      <= leds_d;
		end
	end

	// measured voltage in centivolts, payload only
	always_ff @(posedge clk) begin
		if (upd) begin
			cap_q <= 16'(item.volt_code) * 16'd14;
		end
	end

	assign rsp.charge_level    = pins_q[kcfc_pkg::PIN_CHARGE];
	assign rsp.discharge_level = pins_q[kcfc_pkg::PIN_DISCHARGE];
	assign rsp.straight_level  = pins_q[kcfc_pkg::PIN_STRAIGHT];
	assign rsp.chip_level      = pins_q[kcfc_pkg::PIN_CHIP];
	assign rsp.led_deep        = leds_q[0];
	assign rsp.led_front       = leds_q[1];
	assign rsp.ready_res       = in_band_q;
	assign rsp.phase_out       = phase_q;
	assign rsp.cap_centivolts  = cap_q;

endmodule

@@ rtl/kicker_charge_and_fire_control_top.sv @@
// Kicker charge and fire control: one control tick per request, one result per request.
// A request is taken every cycle while the result side keeps up; its result passes through
// the input register, then the control/result register, with the scaling multiply, band
// compare and next-state logic between them. Throughput is one request per cycle while
// the result side keeps up, set by the control stage, which updates the phase, band flag,
// fire time and pin levels once per request. A stalled result holds the result register,
// the input register still fills while empty, and req_stall rises once both are full.
module kicker_charge_and_fire_control_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  kcfc_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output kcfc_pkg::rsp_t rsp_data
);

	logic             valid_s1;
	kcfc_pkg::req_t   req_s1;
	kcfc_pkg::stage_t scaled;
	logic             rsp_valid_q;
	logic             ld_out;
	logic             ld_s1;
	logic [11:0]      volt_code;

	// stage load enables, each stage moves when empty or when the next one moves
	assign ld_out    = !rsp_valid_q || !rsp_stall;
	assign ld_s1     = !valid_s1 || ld_out;
	assign req_stall = !ld_s1;
	assign rsp_valid = rsp_valid_q;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				valid_s1 <= req_valid;
			end
			if (ld_out) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ld_s1 && req_valid) begin
			req_s1 <= req_data;
		end
	end

	kcfc_scale u_scale (
		.adc_code  (req_s1.adc_code),
		.volt_code (volt_code)
	);

	// scaled request, sensors turned active high
	always_comb begin
		scaled.volt_code  = volt_code;
		scaled.now_us     = req_s1.now_us;
		scaled.kick_power = req_s1.kick_power;
		scaled.kick_mode  = req_s1.kick_mode;
		scaled.deep_n     = !req_s1.deep_sensor_level;
		scaled.front_n    = !req_s1.front_sensor_level;
	end

	kcfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (ld_out && valid_s1),
		.item   (scaled),
		.rsp    (rsp_data)
	);

endmodule

@@ rtl/kcfc_check.sv @@
// port-level checks for the kicker control, bound to the top level
module kcfc_check (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input kcfc_pkg::rsp_t rsp_data
);

	// a stalled result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// charging or dumping only while outside the band
	a_pump_out_of_band: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (!rsp_data.charge_level || !rsp_data.discharge_level)
		|-> !rsp_data.ready_res)
		else $error("charge or discharge active while in band");

	// kick phase is entered only in band with all pins idle
	a_kick_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.phase_out == kcfc_pkg::PH_KICK
		|-> rsp_data.ready_res && rsp_data.charge_level && rsp_data.discharge_level
			&& rsp_data.straight_level && rsp_data.chip_level)
		else $error("kick phase without band or with active pin");

	// after a kick exactly one solenoid pin is low
	a_after_kick: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.phase_out == kcfc_pkg::PH_AFTER
		|-> rsp_data.ready_res && (rsp_data.straight_level != rsp_data.chip_level))
		else $error("after-kick phase without exactly one fired solenoid");

endmodule

bind kicker_charge_and_fire_control_top kcfc_check u_check (.*);

@@ tb/kicker_charge_and_fire_control_top_tb.sv @@
// testbench for the kicker charge and fire control block against a tick predictor
module kicker_charge_and_fire_control_top_tb;

	// band half-width limits and other voltage points, in 1/1400 V
	localparam int BOUND_MIN = 7000;
	localparam int BOUND_MAX = 14000;
	// highest converter code that still reads below 10 V
	localparam logic [11:0] LOW_CODE_MAX = 12'd89;
	localparam int QUIET_LIMIT = 2000;
	localparam int TICKS_PER_PHASE = 360;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	kcfc_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	kcfc_pkg::rsp_t rsp_data;

	// requests waiting to be sent and results predicted for accepted requests
	kcfc_pkg::req_t tick_queue[$];
	kcfc_pkg::rsp_t predicted_outputs[$];

	int mismatch_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int tick_count = 0;
	logic [31:0] tick_us = '0;

	// predicted controller state
	logic [1:0]  ctl_phase = kcfc_pkg::PH_PREPARE;
	logic        ctl_ready = 1'b0;
	logic [31:0] ctl_fire_us = '0;
	logic [3:0]  ctl_pins = 4'hF;
	logic [1:0]  ctl_leds = 2'b00;

	kicker_charge_and_fire_control_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one control tick of the kicker: updates the predicted state, returns the pin picture
	function automatic kcfc_pkg::rsp_t kicker_tick(kcfc_pkg::req_t r);
		int unsigned mv;
		longint actual;
		longint target;
		longint bound;
		longint diff;
		logic ball_deep;
		logic ball_front;
		logic [31:0] elapsed;
		int fire_pin;
		kcfc_pkg::rsp_t o;
		mv = (32'(r.adc_code) * 32'd3300) / 32'd4095;
		actual = longint'(mv) * 196;
		target = 0;
		if (r.kick_power != 4'd0)
			target = ((longint'(r.kick_power) - 1) * 230 + 1400) * 100;
		ball_deep = !r.deep_sensor_level;
		ball_front = !r.front_sensor_level;
		fire_pin = -1;
		if (ctl_phase == kcfc_pkg::PH_PREPARE || !ctl_ready) begin
			// charge or bleed toward the band around the target
			bound = target / 20;
			if (bound < BOUND_MIN)
				bound = BOUND_MIN;
			else if (bound > BOUND_MAX)
				bound = BOUND_MAX;
			diff = target - actual;
			ctl_pins[kcfc_pkg::PIN_STRAIGHT] = 1'b1;
			ctl_pins[kcfc_pkg::PIN_CHIP] = 1'b1;
			if (diff > bound) begin
				ctl_pins[kcfc_pkg::PIN_DISCHARGE] = 1'b1;
				ctl_pins[kcfc_pkg::PIN_CHARGE] = 1'b0;
				ctl_ready = 1'b0;
			end else if (diff < -bound) begin
				ctl_pins[kcfc_pkg::PIN_DISCHARGE] = 1'b0;
				ctl_pins[kcfc_pkg::PIN_CHARGE] = 1'b1;
				ctl_ready = 1'b0;
			end else begin
				ctl_pins[kcfc_pkg::PIN_DISCHARGE] = 1'b1;
				ctl_pins[kcfc_pkg::PIN_CHARGE] = 1'b1;
				ctl_ready = 1'b1;
				if (r.kick_mode != kcfc_pkg::MODE_OFF)
					ctl_phase = kcfc_pkg::PH_KICK;
			end
			ctl_leds = {ball_front, ball_deep};
		end else if (ctl_phase == kcfc_pkg::PH_KICK) begin
			// fire now or on the sensors, otherwise fall back to prepare
			ctl_pins[kcfc_pkg::PIN_DISCHARGE] = 1'b1;
			ctl_pins[kcfc_pkg::PIN_CHARGE] = 1'b1;
			ctl_phase = kcfc_pkg::PH_PREPARE;
			case (r.kick_mode)
				kcfc_pkg::MODE_KICK_FRONT: fire_pin = kcfc_pkg::PIN_STRAIGHT;
				kcfc_pkg::MODE_KICK_UP: fire_pin = kcfc_pkg::PIN_CHIP;
				kcfc_pkg::MODE_AUTO_FRONT:
					if (ball_deep && ball_front) fire_pin = kcfc_pkg::PIN_STRAIGHT;
				kcfc_pkg::MODE_AUTO_UP:
					if (ball_deep && ball_front) fire_pin = kcfc_pkg::PIN_CHIP;
				kcfc_pkg::MODE_AUTO_MOMENTUM:
					if (ball_deep || ball_front) fire_pin = kcfc_pkg::PIN_STRAIGHT;
				default: fire_pin = -1;
			endcase
			if (fire_pin >= 0) begin
				ctl_fire_us = r.now_us;
				ctl_pins[fire_pin] = 1'b0;
				ctl_phase = kcfc_pkg::PH_AFTER;
			end
		end else if (ctl_phase == kcfc_pkg::PH_AFTER) begin
			// re-arm once settled and the capacitor is low
			elapsed = r.now_us - ctl_fire_us;
			if (elapsed > kcfc_pkg::SETTLE_US && actual < longint'(kcfc_pkg::VOLT_10))
				ctl_phase = kcfc_pkg::PH_PREPARE;
		end
		o.charge_level = ctl_pins[kcfc_pkg::PIN_CHARGE];
		o.discharge_level = ctl_pins[kcfc_pkg::PIN_DISCHARGE];
		o.straight_level = ctl_pins[kcfc_pkg::PIN_STRAIGHT];
		o.chip_level = ctl_pins[kcfc_pkg::PIN_CHIP];
		o.led_deep = ctl_leds[0];
		o.led_front = ctl_leds[1];
		o.ready_res = ctl_ready;
		o.phase_out = ctl_phase;
		o.cap_centivolts = 16'(mv * 14);
		return o;
	endfunction

	task automatic add_tick(logic [11:0] code, logic [31:0] now, logic [3:0] power,
			logic [2:0] mode, logic deep, logic front);
		kcfc_pkg::req_t r;
		r.adc_code = code;
		r.now_us = now;
		r.kick_power = power;
		r.kick_mode = mode;
		r.deep_sensor_level = deep;
		r.front_sensor_level = front;
		tick_queue.push_back(r);
		tick_count++;
	endtask

	// converter code near the middle of the band for a power setting, sometimes just outside
	function automatic logic [11:0] band_code(logic [3:0] power);
		longint target;
		longint c;
		target = 0;
		if (power != 4'd0)
			target = ((longint'(power) - 1) * 230 + 1400) * 100;
		c = target * 4095 / (196 * 3300) + longint'($urandom_range(0, 100)) - 50;
		if (c < 0)
			c = 0;
		else if (c > 4095)
			c = 4095;
		return 12'(c);
	endfunction

	// recover to prepare, charge, arm, kick, then wait out the after-kick phase
	task automatic kick_sequence();
		logic [3:0] power;
		logic [2:0] mode;
		power = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 9) == 0)
			mode = 3'($urandom_range(0, 7));
		else
			mode = 3'($urandom_range(1, 5));
		tick_us += 32'd20000 + $urandom_range(0, 5000);
		add_tick(12'($urandom_range(0, LOW_CODE_MAX)), tick_us, power, kcfc_pkg::MODE_OFF,
			1'($urandom), 1'($urandom));
		repeat ($urandom_range(0, 3)) begin
			tick_us += $urandom_range(1, 3000);
			add_tick(12'($urandom), tick_us, power, mode, 1'($urandom), 1'($urandom));
		end
		tick_us += $urandom_range(1, 3000);
		add_tick(band_code(power), tick_us, power, mode, 1'($urandom), 1'($urandom));
		if ($urandom_range(0, 7) == 0)
			mode = 3'($urandom_range(0, 7));
		tick_us += $urandom_range(1, 3000);
		add_tick(12'($urandom), tick_us, power, mode, 1'($urandom), 1'($urandom));
		repeat ($urandom_range(1, 4)) begin
			tick_us += $urandom_range(0, 6000);
			if ($urandom_range(0, 1) == 0)
				add_tick(12'($urandom_range(0, LOW_CODE_MAX + 2)), tick_us, power, mode,
					1'($urandom), 1'($urandom));
			else
				add_tick(12'($urandom), tick_us, power, mode, 1'($urandom), 1'($urandom));
		end
	endtask

	task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			if (mismatch_count < 10)
				$display("mismatch on %s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// request driver: holds a stalled request, otherwise sends or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				predicted_outputs.push_back(kicker_tick(req_data));
			if (!req_valid || !req_stall) begin
				if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_data <= tick_queue.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		kcfc_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_outputs.size() == 0) begin
					if (mismatch_count < 10)
						$display("result with no request outstanding: %h", rsp_data);
					mismatch_count++;
				end else begin
					want = predicted_outputs.pop_front();
					check_field("charge_level", 16'(want.charge_level),
						16'(rsp_data.charge_level));
					check_field("discharge_level", 16'(want.discharge_level),
						16'(rsp_data.discharge_level));
					check_field("straight_level", 16'(want.straight_level),
						16'(rsp_data.straight_level));
					check_field("chip_level", 16'(want.chip_level),
						16'(rsp_data.chip_level));
					check_field("led_deep", 16'(want.led_deep), 16'(rsp_data.led_deep));
					check_field("led_front", 16'(want.led_front), 16'(rsp_data.led_front));
					check_field("ready_res", 16'(want.ready_res), 16'(rsp_data.ready_res));
					check_field("phase_out", 16'(want.phase_out), 16'(rsp_data.phase_out));
					check_field("cap_centivolts", want.cap_centivolts, rsp_data.cap_centivolts);
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// stimulus: directed ticks, then random phases with different idling
	initial begin
		logic [31:0] t;
		int phase_idx;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// rail codes and powers: bleed, then charge
		add_tick(12'hFFF, 32'hFFFF_FFFF, 4'd0, kcfc_pkg::MODE_OFF, 1'b1, 1'b1);
		add_tick(12'd0, 32'd0, 4'd15, kcfc_pkg::MODE_OFF, 1'b0, 1'b0);
		// straight kick across the timestamp wrap, re-arm edges on time and voltage
		t = 32'hFFFF_F000;
		add_tick(12'd0, t, 4'd0, kcfc_pkg::MODE_KICK_FRONT, 1'b1, 1'b1);
		add_tick(12'd0, t, 4'd0, kcfc_pkg::MODE_KICK_FRONT, 1'b1, 1'b1);
		add_tick(12'd0, t + 32'd10000, 4'd0, kcfc_pkg::MODE_KICK_FRONT, 1'b1, 1'b1);
		add_tick(LOW_CODE_MAX + 12'd1, t + 32'd10001, 4'd0, kcfc_pkg::MODE_KICK_FRONT,
			1'b1, 1'b1);
		add_tick(LOW_CODE_MAX, t + 32'd10001, 4'd0, kcfc_pkg::MODE_KICK_FRONT, 1'b1, 1'b1);
		// chip kick
		t = t + 32'd20000;
		add_tick(12'd0, t, 4'd0, kcfc_pkg::MODE_KICK_UP, 1'b1, 1'b0);
		add_tick(12'd0, t, 4'd0, kcfc_pkg::MODE_KICK_UP, 1'b1, 1'b0);
		add_tick(12'd0, t + 32'd10001, 4'd0, kcfc_pkg::MODE_KICK_UP, 1'b0, 1'b1);
		// auto front with no ball: falls back to prepare
		add_tick(12'd0, t + 32'd10002, 4'd0, kcfc_pkg::MODE_AUTO_FRONT, 1'b1, 1'b1);
		add_tick(12'd0, t + 32'd10003, 4'd0, kcfc_pkg::MODE_AUTO_FRONT, 1'b1, 1'b1);
		// auto up with ball at both sensors
		t = t + 32'd20000;
		add_tick(12'd0, t, 4'd0, kcfc_pkg::MODE_AUTO_UP, 1'b0, 1'b0);
		add_tick(12'd0, t, 4'd0, kcfc_pkg::MODE_AUTO_UP, 1'b0, 1'b0);
		add_tick(12'd0, t + 32'd10001, 4'd0, kcfc_pkg::MODE_AUTO_UP, 1'b0, 1'b0);
		// auto momentum with ball at the front only
		t = t + 32'd20000;
		add_tick(12'd0, t, 4'd0, kcfc_pkg::MODE_AUTO_MOMENTUM, 1'b1, 1'b0);
		add_tick(12'd0, t, 4'd0, kcfc_pkg::MODE_AUTO_MOMENTUM, 1'b1, 1'b0);
		add_tick(12'd0, t + 32'd10001, 4'd0, kcfc_pkg::MODE_AUTO_MOMENTUM, 1'b1, 1'b1);
		// unused modes arm but never fire
		add_tick(12'd0, t + 32'd10002, 4'd0, 3'd6, 1'b1, 1'b1);
		add_tick(12'd0, t + 32'd10003, 4'd0, 3'd7, 1'b1, 1'b1);
		// mode dropped to disabled between arm and kick
		add_tick(12'd0, t + 32'd10004, 4'd0, kcfc_pkg::MODE_KICK_FRONT, 1'b1, 1'b1);
		add_tick(12'd0, t + 32'd10005, 4'd0, kcfc_pkg::MODE_OFF, 1'b1, 1'b1);
		// top power inside its band
		add_tick(band_code(4'd15), t + 32'd10006, 4'd15, kcfc_pkg::MODE_OFF, 1'b0, 1'b1);

		tick_us = $urandom;
		for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
			case (phase_idx)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 53; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 53; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			tick_count = 0;
			while (tick_count < TICKS_PER_PHASE) begin
				if ($urandom_range(0, 4) == 0) begin
					// noise: any field value, timestamps anywhere
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 1) == 0)
							tick_us += $urandom_range(0, 12000);
						else
							tick_us = $urandom;
						add_tick(12'($urandom), tick_us, 4'($urandom), 3'($urandom),
							1'($urandom), 1'($urandom));
					end
				end else begin
					kick_sequence();
				end
			end
			// hold off until every request has come back
			while (tick_queue.size() != 0 || req_valid || predicted_outputs.size() != 0)
				@(negedge clk);
		end
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && predicted_outputs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
